// ===== rtl/ios_pkg.sv =====
// shared types and constants for the interval overlap search tree
package ios_pkg;

    // coordinate width of one interval bound
    localparam int unsigned COORD_W = 31;

    // sequencer states, one-hot
    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_WALK_RD = 7'b0000010,
        ST_WALK_EV = 7'b0000100,
        ST_WALK_END = 7'b0001000,
        ST_BLD_RDL = 7'b0010000,
        ST_BLD_RDR = 7'b0100000,
        ST_BLD_WR  = 7'b1000000
    } state_t;

    // input function codes
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

endpackage

// ===== rtl/interval_overlap_search_tree.sv =====
// Interval overlap search tree: leaves and internal nodes live in two synchronous
// memories with registered read data. A load writes one leaf; a load marked last
// then rebuilds the n-1 internal nodes bottom-up, each from two child reads through
// the shared read path and one write. A query walks the heap in preorder, reading
// each visited node and then comparing and stepping, closes in a final state, and
// stalls while the result register is still held. Only one transaction is in work
// at a time; s_ready is high only between transactions.
module interval_overlap_search_tree
    import ios_pkg::*;
#(
    parameter int unsigned MAX_LEAVES = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [6:0]   cfg_wdata,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic         s_func,
    input  logic [5:0]   s_leaf_index,
    input  logic [30:0]  s_low_coord,
    input  logic [30:0]  s_high_coord,
    input  logic         s_is_last_load,
    output logic         m_valid,
    input  logic         m_ready,
    output logic [5:0]   m_fragment_index,
    output logic         m_found,
    output logic         m_last_result
);

    localparam int unsigned LW  = (MAX_LEAVES > 1) ? $clog2(MAX_LEAVES) : 1;
    localparam int unsigned NW  = $clog2(MAX_LEAVES + 1);
    localparam int unsigned PW  = $clog2(2 * MAX_LEAVES - 1);
    localparam int unsigned XW  = PW + 1;
    localparam int unsigned SD  = LW + 1;
    localparam int unsigned SPW = $clog2(SD + 1);
    localparam int unsigned SIW = (SD > 1) ? $clog2(SD) : 1;
    localparam int unsigned BW  = 2 * COORD_W;

    // storage
    logic [BW-1:0] leaf_mem [MAX_LEAVES];
    logic [BW-1:0] node_mem [MAX_LEAVES-1];
    logic [PW-1:0] stack_reg [SD];

    state_t            state_reg, state_next;
    logic [6:0]        leaf_count_reg;
    logic [PW-1:0]     pos_reg, pos_next;
    logic [SPW-1:0]    sp_reg, sp_next;
    logic [LW-1:0]     bi_reg, bi_next;
    logic [COORD_W-1:0] qlo_reg, qlo_next, qhi_reg, qhi_next;
    logic [COORD_W-1:0] llo_reg, llo_next, lhi_reg, lhi_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [5:0]        pend_slot_reg, pend_slot_next;
    logic              m_valid_reg, m_valid_next;
    logic [5:0]        m_frag_reg, m_frag_next;
    logic              m_found_reg, m_found_next;
    logic              m_last_reg, m_last_next;
    logic [BW-1:0]     leaf_rd_reg, node_rd_reg;
    logic              rd_leaf_reg;

    logic [NW-1:0]     n_used;
    logic [XW-1:0]     s_pow, u_val, nm1, p_val, slot_x;
    logic [PW-1:0]     rd_pos;
    logic              rd_en, rd_is_node;
    logic [LW-1:0]     slot;
    logic [BW-1:0]     rd_data;
    logic [COORD_W-1:0] rd_lo, rd_hi;
    logic              hit, out_free, push, leaf_we, node_we;
    logic [PW-1:0]     stack_top;

    // leaf count in use and the leaf rotation offset
    always_comb begin
        if (leaf_count_reg == 7'd0) begin
            n_used = NW'(1);
        end else if (32'(leaf_count_reg) > MAX_LEAVES) begin
            n_used = NW'(MAX_LEAVES);
        end else begin
            n_used = NW'(leaf_count_reg);
        end
        s_pow = XW'(1);
        for (int i = 0; i < NW; i++) begin
            if (n_used[i]) s_pow = XW'(1) << (i + 1);
        end
        u_val = s_pow - XW'(n_used);
        nm1   = XW'(n_used) - XW'(1);
    end

    // read address and heap position to fragment slot
    always_comb begin
        unique case (state_reg)
            ST_BLD_RDL: rd_pos = PW'({bi_reg, 1'b1});
            ST_BLD_RDR: rd_pos = PW'({bi_reg, 1'b0}) + PW'(2);
            default:    rd_pos = pos_reg;
        endcase
        rd_en      = (state_reg == ST_WALK_RD) || (state_reg == ST_BLD_RDL) ||
                     (state_reg == ST_BLD_RDR);
        rd_is_node = XW'(rd_pos) < nm1;
        p_val      = XW'(rd_pos) - nm1;
        if (p_val < u_val) begin
            slot_x = p_val + XW'(n_used) - u_val;
        end else begin
            slot_x = p_val - u_val;
        end
        slot = LW'(slot_x);
    end

    assign rd_data  = rd_leaf_reg ? leaf_rd_reg : node_rd_reg;
    assign rd_lo    = rd_data[COORD_W-1:0];
    assign rd_hi    = rd_data[BW-1:COORD_W];
    assign hit      = ((rd_lo <= qlo_reg) && (qlo_reg <= rd_hi)) ||
                      ((qlo_reg <= rd_lo) && (rd_lo <= qhi_reg));
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign leaf_we  = s_valid && s_ready && (s_func == FUNC_LOAD) &&
                      (32'(s_leaf_index) < MAX_LEAVES);
    assign node_we  = (state_reg == ST_BLD_WR);
    assign stack_top = stack_reg[SIW'(sp_reg - SPW'(1))];

    // sequencer
    always_comb begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        sp_next         = sp_reg;
        bi_next         = bi_reg;
        qlo_next        = qlo_reg;
        qhi_next        = qhi_reg;
        llo_next        = llo_reg;
        lhi_next        = lhi_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_frag_next     = m_frag_reg;
        m_found_next    = m_found_reg;
        m_last_next     = m_last_reg;
        push            = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_func == FUNC_QUERY) begin
                        qlo_next        = s_low_coord;
                        qhi_next        = s_high_coord;
                        pos_next        = '0;
                        sp_next         = '0;
                        pend_valid_next = 1'b0;
                        state_next      = ST_WALK_RD;
                    end else if (s_is_last_load && (n_used > NW'(1))) begin
                        bi_next    = LW'(n_used - NW'(2));
                        state_next = ST_BLD_RDL;
                    end
                end
            end
            ST_WALK_RD: state_next = ST_WALK_EV;
            ST_WALK_EV: begin
                if (hit && !rd_leaf_reg) begin
                    // descend left, keep the right child for later
                    push       = 1'b1;
                    sp_next    = sp_reg + SPW'(1);
                    pos_next   = PW'({pos_reg, 1'b1});
                    state_next = ST_WALK_RD;
                end else if (!(hit && pend_valid_reg && !out_free)) begin
                    // emit the held hit before keeping the new one
                    if (hit) begin
                        if (pend_valid_reg) begin
                            m_valid_next = 1'b1;
                            m_frag_next  = pend_slot_reg;
                            m_found_next = 1'b1;
                            m_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_slot_next  = 6'(slot);
                    end
                    if (sp_reg != '0) begin
                        pos_next   = stack_top;
                        sp_next    = sp_reg - SPW'(1);
                        state_next = ST_WALK_RD;
                    end else begin
                        state_next = ST_WALK_END;
                    end
                end
            end
            ST_WALK_END: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_frag_next  = pend_valid_reg ? pend_slot_reg : 6'd0;
                    m_found_next = pend_valid_reg;
                    m_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_BLD_RDL: state_next = ST_BLD_RDR;
            ST_BLD_RDR: begin
                llo_next   = rd_lo;
                lhi_next   = rd_hi;
                state_next = ST_BLD_WR;
            end
            ST_BLD_WR: begin
                if (bi_reg == '0) begin
                    state_next = ST_IDLE;
                end else begin
                    bi_next    = bi_reg - LW'(1);
                    state_next = ST_BLD_RDL;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control and payload registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            leaf_count_reg <= 7'd1;
            sp_reg         <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            sp_reg         <= sp_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_we) leaf_count_reg <= cfg_wdata;
        end
        pos_reg       <= pos_next;
        bi_reg        <= bi_next;
        qlo_reg       <= qlo_next;
        qhi_reg       <= qhi_next;
        llo_reg       <= llo_next;
        lhi_reg       <= lhi_next;
        pend_slot_reg <= pend_slot_next;
        m_frag_reg    <= m_frag_next;
        m_found_reg   <= m_found_next;
        m_last_reg    <= m_last_next;
        if (push) stack_reg[SIW'(sp_reg)] <= PW'({pos_reg, 1'b0}) + PW'(2);
    end

    // leaf and node memories, one read port each with registered data
    always_ff @(posedge aclk) begin
        if (leaf_we) leaf_mem[LW'(s_leaf_index)] <= {s_high_coord, s_low_coord};
        if (node_we) begin
            node_mem[bi_reg] <= {((lhi_reg > rd_hi) ? lhi_reg : rd_hi),
                                 ((llo_reg < rd_lo) ? llo_reg : rd_lo)};
        end
        if (rd_en) begin
            rd_leaf_reg <= !rd_is_node;
            if (rd_is_node) begin
                node_rd_reg <= node_mem[LW'(rd_pos)];
            end else begin
                leaf_rd_reg <= leaf_mem[slot];
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_fragment_index = m_frag_reg;
    assign m_found          = m_found_reg;
    assign m_last_result    = m_last_reg;

`ifndef SYNTHESIS
    // walk stack never overflows its depth
    a_stack_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(sp_reg) <= SD) else $error("walk stack overflow");

    // a last load with internal nodes starts the rebuild
    a_rebuild_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_func == FUNC_LOAD) && s_is_last_load &&
         (n_used > NW'(1))) |=> (state_reg == ST_BLD_RDL))
        else $error("rebuild not started");

    // node writes stay among the internal nodes
    a_node_range: assert property (@(posedge aclk) disable iff (!aresetn)
        node_we |-> (XW'(bi_reg) < nm1)) else $error("node write out of range");

    // a no-hit result is always the final one
    a_nohit_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_found_reg) |-> m_last_reg) else $error("no-hit not last");
`endif

endmodule
